// ===== src/sskn_pkg.sv =====
// ----------------------------------------------------------------------------
// sskn_pkg
// Shared types and constants of the sparse Sinkhorn normalizer.
// ----------------------------------------------------------------------------
package sskn_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int W_W          = 32;
    localparam int SUM_W        = 38;
    localparam int DIVD_W       = W_W + 16;
    localparam int GRP_W        = 6;
    localparam int SCL_W        = 16;
    localparam int LIM_W        = 16;
    localparam int CHG_W        = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [W_W-1:0]   W_MAX   = {W_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE   = 2'd0,
        CFG_DUMMY_SIDE  = 2'd1,
        CFG_DUMMY_SCALE = 2'd2,
        CFG_ITER_LIMIT  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] SIDE_FIRST  = 2'd1;
    localparam logic [1:0] SIDE_SECOND = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_WT,
        S_CHECK,
        S_COPY_RD,
        S_COPY_WR,
        S_SUM_RD,
        S_SUM_IX,
        S_SUM_ACC,
        S_BACK_CHK,
        S_BACK_UPD,
        S_DIV_RD,
        S_DIV_IX,
        S_DIV_GO,
        S_DIV_WT,
        S_DOM_END,
        S_SCL_RD,
        S_SCL_MUL,
        S_SCL_WR,
        S_CHG_RD,
        S_CHG_DIF,
        S_CHG_SQ,
        S_CHG_ACC,
        S_OUT_RD,
        S_OUT_EM
    } t_state;

endpackage

// ===== src/sparse_sinkhorn_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// sparse_sinkhorn_normalizer_top
// Sparse Sinkhorn normalizer: loads up to 64 weights, runs alternating
// row/column normalization passes, then streams the final weights.
// ----------------------------------------------------------------------------
// Usage:
//   Load one element per transfer: start high while busy is low. The weight,
//   both index maps and both group IDs are stored in slot order; items past
//   64 are dropped. An element with is_last set closes the set, raises busy
//   and starts the passes. Config writes (i_cfg_we/idx/data) take effect at
//   once and are meant for idle periods only.
//   Each pass is dominated by the shared bit-serial divider, which runs once
//   per element per domain; passes repeat until the squared change drops
//   below tolerance squared or the iteration limit is hit. Results follow on
//   o_valid in slot order, o_final_result on the last, after which busy drops.
//   The receiver cannot stall; results are presented exactly one cycle.
//   Reset clears the element count and returns to idle; stores hold no reset.
// ----------------------------------------------------------------------------
module sparse_sinkhorn_normalizer_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sskn_pkg::W_W-1:0]           i_weight,
    input  logic [sskn_pkg::GRP_W-1:0]         i_first_index,
    input  logic [sskn_pkg::GRP_W-1:0]         i_first_group,
    input  logic [sskn_pkg::GRP_W-1:0]         i_second_index,
    input  logic [sskn_pkg::GRP_W-1:0]         i_second_group,
    input  logic                               i_is_last,
    input  logic                               i_cfg_we,
    input  logic [sskn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sskn_pkg::W_W-1:0]           i_cfg_data,
    output logic                               o_valid,
    output logic [sskn_pkg::W_W-1:0]           o_normalized_weight,
    output logic                               o_final_result
);

    localparam int AW = sskn_pkg::ADDR_W;
    localparam int CW = sskn_pkg::CNT_W;

    sskn_pkg::t_state r_state, n_state;

    // configuration
    logic [sskn_pkg::W_W-1:0]    r_tol;
    logic [1:0]                  r_side;
    logic [sskn_pkg::SCL_W-1:0]  r_scale;
    logic [sskn_pkg::LIM_W-1:0]  r_limit;

    // control and datapath registers
    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               r_n;
    logic [AW-1:0]               r_i;
    logic [AW-1:0]               r_idx;
    logic                        r_dom;
    logic                        r_scaled;
    logic [sskn_pkg::LIM_W-1:0]  r_pass;
    logic [sskn_pkg::CHG_W-1:0]  r_change;
    logic [sskn_pkg::CHG_W-1:0]  r_tol2;
    logic [CW-1:0]               r_grp1;
    logic [CW-1:0]               r_grp2;
    logic [sskn_pkg::SUM_W-1:0]  r_sum;
    logic [sskn_pkg::GRP_W-1:0]  r_g;
    logic [sskn_pkg::GRP_W-1:0]  r_prev_g;
    logic [sskn_pkg::W_W+sskn_pkg::SCL_W-1:0] r_prod;
    logic [sskn_pkg::W_W-1:0]    r_diff;
    logic [sskn_pkg::CHG_W-1:0]  r_sq;

    // memory ports
    logic                        w_ld_we;
    logic                        w_w_we, w_p_we, w_s_we;
    logic [AW-1:0]               w_w_waddr, w_w_raddr, w_s_waddr, w_rd_addr;
    logic [sskn_pkg::W_W-1:0]    w_w_wdata, w_w_rdata, w_p_rdata;
    logic [sskn_pkg::SUM_W-1:0]  w_s_wdata, w_s_rdata;
    logic [sskn_pkg::GRP_W-1:0]  w_ix1_rd, w_g1_rd, w_ix2_rd, w_g2_rd;
    logic [sskn_pkg::GRP_W-1:0]  w_ix_rd, w_g_rd;
    logic                        w_div_start, w_div_done;
    logic [sskn_pkg::W_W-1:0]    w_div_q;

    logic [CW-1:0]               w_nm1;
    logic [AW-1:0]               w_im1;
    logic                        w_last;
    logic [sskn_pkg::SUM_W:0]    w_acc;
    logic [sskn_pkg::SUM_W-1:0]  w_acc_sat;
    logic [sskn_pkg::CHG_W:0]    w_chg_add;
    logic [sskn_pkg::W_W-1:0]    w_prod_sat;
    logic                        w_scale_now;
    logic [CW-1:0]               w_tail_cnt;
    logic [CW-1:0]               w_tail_start;

    assign w_nm1   = r_n - CW'(1);
    assign w_im1   = r_i - AW'(1);
    assign w_last  = ({1'b0, r_i} == w_nm1);
    assign w_ix_rd = r_dom ? w_ix2_rd : w_ix1_rd;
    assign w_g_rd  = r_dom ? w_g2_rd  : w_g1_rd;

    assign w_acc     = {1'b0, r_sum} + {{(sskn_pkg::SUM_W-sskn_pkg::W_W+1){1'b0}}, w_w_rdata};
    assign w_acc_sat = w_acc[sskn_pkg::SUM_W] ? sskn_pkg::SUM_MAX : w_acc[sskn_pkg::SUM_W-1:0];
    assign w_chg_add = {1'b0, r_change} + {1'b0, r_sq};
    assign w_prod_sat = (|r_prod[sskn_pkg::W_W+sskn_pkg::SCL_W-1:sskn_pkg::W_W])
                        ? sskn_pkg::W_MAX : r_prod[sskn_pkg::W_W-1:0];

    assign w_scale_now = !r_scaled &&
                         ((!r_dom && r_side == sskn_pkg::SIDE_FIRST) ||
                          ( r_dom && r_side == sskn_pkg::SIDE_SECOND));
    assign w_tail_cnt   = r_dom ? r_grp1 : r_grp2;
    assign w_tail_start = (w_tail_cnt > r_n) ? '0 : r_n - w_tail_cnt;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sskn_pkg::S_IDLE:     if (start && i_is_last) n_state = sskn_pkg::S_INIT_RD;
            sskn_pkg::S_INIT_RD:  n_state = sskn_pkg::S_INIT_WT;
            sskn_pkg::S_INIT_WT:  n_state = sskn_pkg::S_CHECK;
            sskn_pkg::S_CHECK: begin
                if (r_pass < r_limit && r_change >= r_tol2) n_state = sskn_pkg::S_COPY_RD;
                else n_state = sskn_pkg::S_OUT_RD;
            end
            sskn_pkg::S_COPY_RD:  n_state = sskn_pkg::S_COPY_WR;
            sskn_pkg::S_COPY_WR:  n_state = w_last ? sskn_pkg::S_SUM_RD : sskn_pkg::S_COPY_RD;
            sskn_pkg::S_SUM_RD:   n_state = sskn_pkg::S_SUM_IX;
            sskn_pkg::S_SUM_IX:   n_state = sskn_pkg::S_SUM_ACC;
            sskn_pkg::S_SUM_ACC:  n_state = w_last ? sskn_pkg::S_BACK_CHK : sskn_pkg::S_SUM_RD;
            sskn_pkg::S_BACK_CHK: n_state = (r_i == '0) ? sskn_pkg::S_DIV_RD
                                                         : sskn_pkg::S_BACK_UPD;
            sskn_pkg::S_BACK_UPD: n_state = sskn_pkg::S_BACK_CHK;
            sskn_pkg::S_DIV_RD:   n_state = sskn_pkg::S_DIV_IX;
            sskn_pkg::S_DIV_IX:   n_state = sskn_pkg::S_DIV_GO;
            sskn_pkg::S_DIV_GO:   n_state = sskn_pkg::S_DIV_WT;
            sskn_pkg::S_DIV_WT: begin
                if (w_div_done) n_state = w_last ? sskn_pkg::S_DOM_END : sskn_pkg::S_DIV_RD;
            end
            sskn_pkg::S_DOM_END: begin
                if (w_scale_now) n_state = sskn_pkg::S_SCL_RD;
                else if (!r_dom) n_state = sskn_pkg::S_SUM_RD;
                else n_state = sskn_pkg::S_CHG_RD;
            end
            sskn_pkg::S_SCL_RD:   n_state = sskn_pkg::S_SCL_MUL;
            sskn_pkg::S_SCL_MUL:  n_state = sskn_pkg::S_SCL_WR;
            sskn_pkg::S_SCL_WR:   n_state = w_last ? sskn_pkg::S_DOM_END : sskn_pkg::S_SCL_RD;
            sskn_pkg::S_CHG_RD:   n_state = sskn_pkg::S_CHG_DIF;
            sskn_pkg::S_CHG_DIF:  n_state = sskn_pkg::S_CHG_SQ;
            sskn_pkg::S_CHG_SQ:   n_state = sskn_pkg::S_CHG_ACC;
            sskn_pkg::S_CHG_ACC:  n_state = w_last ? sskn_pkg::S_CHECK : sskn_pkg::S_CHG_RD;
            sskn_pkg::S_OUT_RD:   n_state = sskn_pkg::S_OUT_EM;
            sskn_pkg::S_OUT_EM:   n_state = w_last ? sskn_pkg::S_IDLE : sskn_pkg::S_OUT_RD;
            default:              n_state = sskn_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs and memory controls ----------------
    always_comb begin
        w_ld_we     = 1'b0;
        w_w_we      = 1'b0;
        w_w_waddr   = r_i;
        w_w_wdata   = w_div_q;
        w_w_raddr   = r_i;
        w_p_we      = 1'b0;
        w_s_we      = 1'b0;
        w_s_waddr   = r_i;
        w_s_wdata   = r_sum;
        w_rd_addr   = r_i;
        w_div_start = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            sskn_pkg::S_IDLE: begin
                w_ld_we   = start && !r_cnt[CW-1];
                w_w_we    = w_ld_we;
                w_w_waddr = r_cnt[AW-1:0];
                w_w_wdata = i_weight;
            end
            sskn_pkg::S_INIT_RD:  w_rd_addr = w_nm1[AW-1:0];
            sskn_pkg::S_COPY_WR:  w_p_we = 1'b1;
            sskn_pkg::S_SUM_IX:   w_w_raddr = w_ix_rd;
            sskn_pkg::S_SUM_ACC: begin
                w_s_we    = 1'b1;
                w_s_wdata = (r_i == '0 || r_g != r_prev_g) ? {6'd0, w_w_rdata} : w_acc_sat;
            end
            sskn_pkg::S_BACK_CHK: w_rd_addr = w_im1;
            sskn_pkg::S_BACK_UPD: begin
                w_s_we    = (w_g_rd == r_prev_g);
                w_s_waddr = w_im1;
            end
            sskn_pkg::S_DIV_IX:   w_w_raddr = w_ix_rd;
            sskn_pkg::S_DIV_GO:   w_div_start = 1'b1;
            sskn_pkg::S_DIV_WT: begin
                w_w_we    = w_div_done;
                w_w_waddr = r_idx;
            end
            sskn_pkg::S_SCL_WR: begin
                w_w_we    = 1'b1;
                w_w_wdata = w_prod_sat;
            end
            sskn_pkg::S_OUT_EM:   o_valid = 1'b1;
            default: ;
        endcase
    end

    assign busy                = (r_state != sskn_pkg::S_IDLE);
    assign o_normalized_weight = w_w_rdata;
    assign o_final_result      = (r_state == sskn_pkg::S_OUT_EM) && w_last;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sskn_pkg::S_IDLE;
            r_cnt   <= '0;
            r_tol   <= '0;
            r_side  <= '0;
            r_scale <= sskn_pkg::SCL_W'(1);
            r_limit <= sskn_pkg::LIM_W'(100);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sskn_pkg::CFG_TOLERANCE:   r_tol   <= i_cfg_data;
                    sskn_pkg::CFG_DUMMY_SIDE:  r_side  <= i_cfg_data[1:0];
                    sskn_pkg::CFG_DUMMY_SCALE: r_scale <= i_cfg_data[sskn_pkg::SCL_W-1:0];
                    sskn_pkg::CFG_ITER_LIMIT:  r_limit <= i_cfg_data[sskn_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == sskn_pkg::S_IDLE && start && !r_cnt[CW-1]) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_state == sskn_pkg::S_OUT_EM && w_last) begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            sskn_pkg::S_IDLE: begin
                r_n <= r_cnt + CW'(!r_cnt[CW-1]);
            end
            sskn_pkg::S_INIT_RD: begin
                r_tol2 <= sskn_pkg::CHG_W'(r_tol) * sskn_pkg::CHG_W'(r_tol);
            end
            sskn_pkg::S_INIT_WT: begin
                r_grp1   <= {1'b0, w_g1_rd} + CW'(1);
                r_grp2   <= {1'b0, w_g2_rd} + CW'(1);
                r_change <= r_tol2;
                r_pass   <= '0;
            end
            sskn_pkg::S_CHECK: begin
                if (r_pass < r_limit && r_change >= r_tol2) r_pass <= r_pass + 1'b1;
                r_i      <= '0;
                r_dom    <= 1'b0;
                r_scaled <= 1'b0;
            end
            sskn_pkg::S_COPY_WR: r_i <= w_last ? '0 : r_i + AW'(1);
            sskn_pkg::S_SUM_IX:  r_g <= w_g_rd;
            sskn_pkg::S_SUM_ACC: begin
                r_sum    <= w_s_wdata;
                r_prev_g <= r_g;
                if (!w_last) r_i <= r_i + AW'(1);
            end
            sskn_pkg::S_BACK_CHK: begin
                if (r_i == '0) r_i <= '0;
            end
            sskn_pkg::S_BACK_UPD: begin
                // keep the carried sum inside a run, restart it at a boundary
                if (w_g_rd != r_prev_g) begin
                    r_sum    <= w_s_rdata;
                    r_prev_g <= w_g_rd;
                end
                r_i <= w_im1;
            end
            sskn_pkg::S_DIV_IX: begin
                r_idx <= w_ix_rd;
                r_sum <= w_s_rdata;
            end
            sskn_pkg::S_DIV_WT: begin
                if (w_div_done && !w_last) r_i <= r_i + AW'(1);
            end
            sskn_pkg::S_DOM_END: begin
                if (w_scale_now) begin
                    r_scaled <= 1'b1;
                    r_i      <= w_tail_start[AW-1:0];
                end else begin
                    r_scaled <= 1'b0;
                    r_i      <= '0;
                    if (!r_dom) r_dom <= 1'b1;
                    else r_change <= '0;
                end
            end
            sskn_pkg::S_SCL_MUL: r_prod <= w_w_rdata * r_scale;
            sskn_pkg::S_SCL_WR:  if (!w_last) r_i <= r_i + AW'(1);
            sskn_pkg::S_CHG_DIF: begin
                r_diff <= (w_w_rdata >= w_p_rdata) ? w_w_rdata - w_p_rdata
                                                   : w_p_rdata - w_w_rdata;
            end
            sskn_pkg::S_CHG_SQ:  r_sq <= sskn_pkg::CHG_W'(r_diff) * sskn_pkg::CHG_W'(r_diff);
            sskn_pkg::S_CHG_ACC: begin
                r_change <= w_chg_add[sskn_pkg::CHG_W] ? {sskn_pkg::CHG_W{1'b1}}
                                                       : w_chg_add[sskn_pkg::CHG_W-1:0];
                if (!w_last) r_i <= r_i + AW'(1);
            end
            sskn_pkg::S_OUT_RD: ;
            sskn_pkg::S_OUT_EM:  r_i <= r_i + AW'(1);
            default: ;
        endcase
    end

    // ---------------- stores ----------------
    sskn_ram #(.WIDTH(sskn_pkg::W_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_weight (
        .i_clk(i_clk), .i_we(w_w_we), .i_waddr(w_w_waddr), .i_wdata(w_w_wdata),
        .i_raddr(w_w_raddr), .o_rdata(w_w_rdata)
    );

    sskn_ram #(.WIDTH(sskn_pkg::W_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_previous (
        .i_clk(i_clk), .i_we(w_p_we), .i_waddr(r_i), .i_wdata(w_w_rdata),
        .i_raddr(r_i), .o_rdata(w_p_rdata)
    );

    sskn_ram #(.WIDTH(sskn_pkg::SUM_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_run_sum (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(w_s_wdata),
        .i_raddr(w_rd_addr), .o_rdata(w_s_rdata)
    );

    sskn_ram #(.WIDTH(sskn_pkg::GRP_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_ix1 (
        .i_clk(i_clk), .i_we(w_ld_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(i_first_index),
        .i_raddr(w_rd_addr), .o_rdata(w_ix1_rd)
    );

    sskn_ram #(.WIDTH(sskn_pkg::GRP_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_g1 (
        .i_clk(i_clk), .i_we(w_ld_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(i_first_group),
        .i_raddr(w_rd_addr), .o_rdata(w_g1_rd)
    );

    sskn_ram #(.WIDTH(sskn_pkg::GRP_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_ix2 (
        .i_clk(i_clk), .i_we(w_ld_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(i_second_index),
        .i_raddr(w_rd_addr), .o_rdata(w_ix2_rd)
    );

    sskn_ram #(.WIDTH(sskn_pkg::GRP_W), .DEPTH(sskn_pkg::MAX_ELEMENTS)) u_g2 (
        .i_clk(i_clk), .i_we(w_ld_we), .i_waddr(r_cnt[AW-1:0]), .i_wdata(i_second_group),
        .i_raddr(w_rd_addr), .o_rdata(w_g2_rd)
    );

    sskn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_dividend(w_w_rdata), .i_divisor(r_sum),
        .o_done(w_div_done), .o_quotient(w_div_q)
    );

    // ---------------- assertions ----------------
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_result |=> !busy)
        else $error("busy still high after final result");

    a_valid_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == sskn_pkg::S_DIV_WT)
        else $error("divider finished outside its wait state");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(sskn_pkg::MAX_ELEMENTS))
        else $error("element count beyond store depth");

endmodule

// ===== src/sskn_ram.sv =====
// ----------------------------------------------------------------------------
// sskn_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module sskn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sskn_div.sv =====
// ----------------------------------------------------------------------------
// sskn_div
// Restoring divider, one quotient bit per cycle: (w << 16) / sum, saturated; zero when sum is zero.
// ----------------------------------------------------------------------------
module sskn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sskn_pkg::W_W-1:0]    i_dividend,
    input  logic [sskn_pkg::SUM_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [sskn_pkg::W_W-1:0]    o_quotient
);

    localparam int STEP_W = $clog2(sskn_pkg::DIVD_W + 1);

    logic [STEP_W-1:0]               r_steps;
    logic                            r_run;
    logic                            r_done;
    logic [sskn_pkg::SUM_W-1:0]      r_rem;
    logic [sskn_pkg::DIVD_W-1:0]     r_quo;
    logic [sskn_pkg::SUM_W-1:0]      r_dvs;
    logic [sskn_pkg::SUM_W:0]        w_trial;
    logic [sskn_pkg::SUM_W:0]        w_diff;
    logic                            w_ge;

    assign w_trial = {r_rem, r_quo[sskn_pkg::DIVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_steps <= STEP_W'(sskn_pkg::DIVD_W);
            end else if (r_run) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_dividend, 16'h0000};
            r_dvs <= i_divisor;
        end else if (r_run) begin
            // shift in one dividend bit, subtract when it fits
            r_rem <= w_ge ? w_diff[sskn_pkg::SUM_W-1:0] : w_trial[sskn_pkg::SUM_W-1:0];
            r_quo <= {r_quo[sskn_pkg::DIVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    always_comb begin
        if (r_dvs == '0) begin
            o_quotient = '0;
        end else if (|r_quo[sskn_pkg::DIVD_W-1:sskn_pkg::W_W]) begin
            o_quotient = sskn_pkg::W_MAX;
        end else begin
            o_quotient = r_quo[sskn_pkg::W_W-1:0];
        end
    end

endmodule
